@@ design/priority_ready_queue_unit_macros.svh @@
// Assertion macros for the priority ready queue top level.
`ifndef PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("priority ready queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PRQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("priority ready queue check failed");

`endif

@@ design/prq_pkg.sv @@
// Types and constants of the priority ready queue.
package prq_pkg;

	localparam int ID_W   = 6;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic              command;
		logic [ID_W-1:0]   proc_id;
		logic [PRIO_W-1:0] prio;
	} req_beat_t;

	typedef struct packed {
		logic [ID_W-1:0]   out_id;
		logic [PRIO_W-1:0] out_prio;
		logic [1:0]        status;
		logic [OCC_W-1:0]  occupancy;
	} rsp_beat_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_DEQ_HEAD,
		S_DEQ_SHIFT,
		S_DONE
	} seq_state_t;

endpackage

@@ design/prq_cmp.sv @@
// Shared compare unit: tells whether a new entry goes ahead of a stored slot.
module prq_cmp
	import prq_pkg::*;
(
	input  slot_t             slot,
	input  logic [PRIO_W-1:0] new_prio,
	output logic              hit
);

	assign hit = (slot.id == '0) || (slot.prio < new_prio);

endmodule

@@ design/prq_seq.sv @@
// Sequencer and slot memory: search walk, shift walk and head removal.
module prq_seq
	import prq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_beat_t req,
	input  logic      slot_free,
	output logic      idle,
	output logic      done,
	output rsp_beat_t result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	seq_state_t state_q, state_d;

	slot_t             mem [MAX_ENTRIES];
	slot_t             rdata_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [CW-1:0]     pos_q, pos_d;
	logic              pend_q, pend_d;
	logic [ID_W-1:0]   res_id_q, res_id_d;
	logic [PRIO_W-1:0] res_prio_q, res_prio_d;
	logic [1:0]        res_stat_q, res_stat_d;

	logic          ren, wen;
	logic [CW-1:0] raddr, waddr;
	slot_t         wdata;
	logic          hit;
	logic          full, empty;
	logic [CW-1:0] ptr_inc, j_next;

	prq_cmp u_cmp (
		.slot     (rdata_q),
		.new_prio (prio_q),
		.hit      (hit)
	);

	assign full    = (cnt_q == CW'(MAX_ENTRIES));
	assign empty   = (cnt_q == '0);
	assign ptr_inc = ptr_q + CW'(1);
	assign j_next  = pend_q ? (ptr_q - CW'(1)) : ptr_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.command == CMD_ENQ) begin
						if (full) begin
							state_d = S_DONE;
						end else if ((req.proc_id == '0) || empty) begin
							state_d = S_SHIFT;
						end else begin
							state_d = S_SEARCH;
						end
					end else begin
						state_d = empty ? S_DONE : S_DEQ_HEAD;
					end
				end
			end
			S_SEARCH: begin
				if (hit || (ptr_inc == cnt_q)) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!pend_q && (ptr_q == pos_q)) begin
					state_d = S_DONE;
				end
			end
			S_DEQ_HEAD: begin
				state_d = (cnt_q > CW'(1)) ? S_DEQ_SHIFT : S_DONE;
			end
			S_DEQ_SHIFT: begin
				if (ptr_inc >= cnt_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ren        = 1'b0;
		raddr      = '0;
		wen        = 1'b0;
		waddr      = '0;
		wdata      = rdata_q;
		ptr_d      = ptr_q;
		pos_d      = pos_q;
		pend_d     = pend_q;
		cnt_d      = cnt_q;
		res_id_d   = res_id_q;
		res_prio_d = res_prio_q;
		res_stat_d = res_stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_id_d   = '0;
					res_prio_d = '0;
					res_stat_d = STAT_OK;
					pend_d     = 1'b0;
					if (req.command == CMD_ENQ) begin
						if (full) begin
							res_stat_d = STAT_FULL;
						end else if ((req.proc_id == '0) || empty) begin
							pos_d = cnt_q;
							ptr_d = cnt_q;
						end else begin
							ren   = 1'b1;
							ptr_d = '0;
						end
					end else if (empty) begin
						res_stat_d = STAT_EMPTY;
					end else begin
						ren = 1'b1;
					end
				end
			end
			S_SEARCH: begin
				if (hit) begin
					pos_d  = ptr_q;
					ptr_d  = cnt_q;
					pend_d = 1'b0;
				end else if (ptr_inc == cnt_q) begin
					pos_d  = cnt_q;
					ptr_d  = cnt_q;
					pend_d = 1'b0;
				end else begin
					ren   = 1'b1;
					raddr = ptr_inc;
					ptr_d = ptr_inc;
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					wen   = 1'b1;
					waddr = ptr_q;
					wdata = rdata_q;
				end else if (ptr_q == pos_q) begin
					wen   = 1'b1;
					waddr = pos_q;
					wdata = '{id: id_q, prio: prio_q};
					cnt_d = cnt_q + CW'(1);
				end
				if (j_next > pos_q) begin
					ren    = 1'b1;
					raddr  = j_next - CW'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
				ptr_d = j_next;
			end
			S_DEQ_HEAD: begin
				res_id_d   = rdata_q.id;
				res_prio_d = rdata_q.prio;
				res_stat_d = STAT_OK;
				cnt_d      = cnt_q - CW'(1);
				ptr_d      = '0;
				if (cnt_q > CW'(1)) begin
					ren   = 1'b1;
					raddr = CW'(1);
				end
			end
			S_DEQ_SHIFT: begin
				wen   = 1'b1;
				waddr = ptr_q;
				wdata = rdata_q;
				if (ptr_inc < cnt_q) begin
					ren   = 1'b1;
					raddr = ptr_q + CW'(2);
					ptr_d = ptr_inc;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		pos_q      <= pos_d;
		res_id_q   <= res_id_d;
		res_prio_q <= res_prio_d;
		res_stat_q <= res_stat_d;
		if (state_q == S_IDLE && start) begin
			id_q   <= req.proc_id;
			prio_q <= req.prio;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
		if (wen) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
	end

	assign idle             = (state_q == S_IDLE);
	assign done             = (state_q == S_DONE);
	assign result.out_id    = res_id_q;
	assign result.out_prio  = res_prio_q;
	assign result.status    = res_stat_q;
	assign result.occupancy = OCC_W'(cnt_q);

endmodule

@@ design/priority_ready_queue_unit.sv @@
// Top level of the priority ready queue: request handshake and response register.
// Ready queue of process ids, kept sorted by priority (larger first, FIFO among equals,
// id 0 always at the tail). One request beat is taken at a time; req_ready drops
// until its work is finished, while a finished response may still wait in the
// response register. All slot traffic goes through one memory with a single read and
// a single write port, walked by a small sequencer. An enqueue that lands ahead of
// the entry at pos searches pos + 1 slots, then primes and shifts the count - pos
// slots behind it, places the new entry and hands off; an enqueue that lands at the
// tail searches every slot before it places the entry, and id 0 or an empty queue
// skips the search; a dequeue reads the head, then shifts the rest forward; refused
// beats (full or empty) go straight to hand-off. count is the occupancy before the
// beat. Every beat also waits to hand off while the response register still holds
// an unaccepted beat.
module priority_ready_queue_unit
	import prq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	`include "priority_ready_queue_unit_macros.svh"

	logic      seq_idle, seq_done, slot_free, take;
	rsp_beat_t seq_result;
	logic      rsp_valid_q;
	rsp_beat_t rsp_q;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign take      = seq_done && slot_free;
	assign req_ready = seq_idle;

	prq_seq #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid),
		.req       (req),
		.slot_free (slot_free),
		.idle      (seq_idle),
		.done      (seq_done),
		.result    (seq_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= seq_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PRQ_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
	`PRQ_ASSERT_SAME(a_full_occ, rsp_valid && (rsp.status == STAT_FULL),
		(rsp.occupancy == OCC_W'(MAX_ENTRIES)) && (rsp.out_id == '0))
	`PRQ_ASSERT_SAME(a_empty_occ, rsp_valid && (rsp.status == STAT_EMPTY),
		(rsp.occupancy == '0) && (rsp.out_prio == '0))
	`PRQ_ASSERT_SAME(a_no_take_while_idle, seq_idle, !seq_done)

endmodule

@@ test/priority_ready_queue_unit_test.sv @@
// Testbench for the priority ready queue: directed and random enqueue/dequeue beats checked against a sorted-queue prediction.
module priority_ready_queue_unit_test;
	import prq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_BEATS = 1350;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_beat_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_beat_t rsp;

	req_beat_t cmd_backlog[$];
	rsp_beat_t due_rsp[$];
	slot_t ready_line[$];
	logic req_taken = 1'b0;
	int total_beats = 0;
	int beats_in = 0;
	int req_gap = 0;
	int req_calm = 0;
	int rsp_stall = 0;
	int rsp_calm = 0;
	int quiet_cycles = 0;
	int bad_fields = 0;

	priority_ready_queue_unit #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int pick_wait();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_beat(logic command, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
		req_beat_t b;
		b.command = command;
		b.proc_id = id;
		b.prio = pr;
		cmd_backlog.push_back(b);
	endtask

	function automatic rsp_beat_t apply_sched_op(req_beat_t b);
		rsp_beat_t r;
		slot_t s;
		int pos;
		int i;
		r = '0;
		r.status = STAT_OK;
		if (b.command == CMD_ENQ) begin
			if (ready_line.size() >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				pos = ready_line.size();
				if (b.proc_id != '0) begin
					for (i = 0; i < ready_line.size(); i++)
						if (pos == ready_line.size() &&
						    (ready_line[i].id == '0 || ready_line[i].prio < b.prio))
							pos = i;
				end
				s.id = b.proc_id;
				s.prio = b.prio;
				ready_line.insert(pos, s);
			end
		end else if (ready_line.size() == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			s = ready_line.pop_front();
			r.out_id = s.id;
			r.out_prio = s.prio;
		end
		r.occupancy = OCC_W'(ready_line.size());
		return r;
	endfunction

	task automatic report_mismatch(string note);
		$display("mismatch at %0t: %s", $realtime, note);
		bad_fields++;
	endtask

	task automatic check_rsp(rsp_beat_t got);
		rsp_beat_t want;
		if (due_rsp.size() == 0) begin
			report_mismatch($sformatf("response beat %h with none due", got));
		end else begin
			want = due_rsp.pop_front();
			if (got.out_id !== want.out_id)
				report_mismatch($sformatf("out_id %0d, want %0d", got.out_id, want.out_id));
			if (got.out_prio !== want.out_prio)
				report_mismatch($sformatf("out_prio %0d, want %0d", got.out_prio,
					want.out_prio));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy,
					want.occupancy));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && req_ready;
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (req_valid && req_ready) begin
				due_rsp.push_back(apply_sched_op(req));
				beats_in <= beats_in + 1;
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			if (!req_valid || req_taken) begin
				if (req_gap > 0) begin
					req_valid <= 1'b0;
					req_gap <= req_gap - 1;
				end else if (cmd_backlog.size() > 0) begin
					req_valid <= 1'b1;
					req <= cmd_backlog.pop_front();
					if (req_calm > 0) begin
						req_calm <= req_calm - 1;
					end else begin
						req_gap <= pick_wait();
						if ($urandom_range(0, 49) == 0)
							req_calm <= $urandom_range(20, 60);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
			if (rsp_stall > 0) begin
				rsp_ready <= 1'b0;
				rsp_stall <= rsp_stall - 1;
			end else begin
				rsp_ready <= 1'b1;
				if (rsp_calm > 0)
					rsp_calm <= rsp_calm - 1;
				else if ($urandom_range(0, 3) == 0)
					rsp_stall <= pick_wait();
				else if ($urandom_range(0, 99) == 0)
					rsp_calm <= $urandom_range(30, 90);
			end
		end
	end

	initial begin
		int made;
		int mode;
		int span;
		int r;
		int pick;
		logic [ID_W-1:0] id;
		logic [PRIO_W-1:0] pr;

		push_beat(CMD_DEQ, '1, '1);
		push_beat(CMD_ENQ, 6'd63, 8'd255);
		push_beat(CMD_ENQ, 6'd0, 8'd0);
		push_beat(CMD_ENQ, 6'd0, 8'd255);
		push_beat(CMD_ENQ, 6'd5, 8'd255);
		push_beat(CMD_ENQ, 6'd9, 8'd0);
		push_beat(CMD_ENQ, 6'd5, 8'd255);
		push_beat(CMD_ENQ, 6'd42, 8'd128);
		push_beat(CMD_ENQ, 6'd1, 8'd1);
		repeat (9) push_beat(CMD_DEQ, '0, '0);

		made = 0;
		while (made < RANDOM_BEATS) begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(5, 40);
			repeat (span) begin
				pick = $urandom_range(0, 99);
				if (pick < 15)
					id = '0;
				else if (pick < 35)
					id = ID_W'($urandom_range(1, 3));
				else
					id = ID_W'($urandom_range(0, 63));
				pick = $urandom_range(0, 99);
				if (pick < 25)
					pr = PRIO_W'($urandom_range(0, 3));
				else if (pick < 35)
					pr = '1;
				else
					pr = PRIO_W'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if ((mode == 0 && r < 85) || (mode == 1 && r < 15) || (mode == 2 && r < 50))
					push_beat(CMD_ENQ, id, pr);
				else
					push_beat(CMD_DEQ, id, pr);
				made++;
			end
		end
		total_beats = cmd_backlog.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_in < total_beats || due_rsp.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (bad_fields == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
